[rtl/core/sspd_pkg.sv]
// Shared types and constants for the servo status packet deframer.
package sspd_pkg;

  // Header byte and default parameter buffer depth
  localparam logic [7:0] HEADER_BYTE        = 8'hFF;
  localparam int         DEFAULT_MAX_PARAMS = 32;

  // Result status codes
  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_BAD_SUM = 2'd2;
  localparam logic [1:0] ST_BAD_LEN = 2'd3;

  // Parser phases, one-hot
  typedef enum logic [7:0] {
    PH_HUNT1 = 8'b0000_0001,
    PH_HUNT2 = 8'b0000_0010,
    PH_ID    = 8'b0000_0100,
    PH_LEN   = 8'b0000_1000,
    PH_ERR   = 8'b0001_0000,
    PH_PARAM = 8'b0010_0000,
    PH_CHK   = 8'b0100_0000,
    PH_DRAIN = 8'b1000_0000
  } phase_t;

endpackage

[rtl/core/servo_status_packet_deframer.sv]
// Top level of the servo status packet deframer: parser, buffer drain and output register.
//
// Bytes enter one word per cycle: in_ready is high in every parsing phase,
// except that a byte which may produce a result (the length byte and the
// checksum byte) waits until the output register is free or being taken.
// in_abort drops a partial packet and emits nothing. After a good checksum
// with N parameter bytes, the block stops taking input while the buffer is
// read out through its single read port, one parameter word per cycle
// unless out_ready stalls; the read of entry zero is issued with the
// checksum byte. A bad length, bad checksum or parameterless packet gives
// one word.
// The parameter buffer needs no clearing after reset: only entries written
// earlier in the same packet are read.
module servo_status_packet_deframer #(
  parameter int MAX_PARAMS = sspd_pkg::DEFAULT_MAX_PARAMS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_abort,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_servo_id,
  output logic [7:0] out_error_flags,
  output logic [4:0] out_param_index,
  output logic [7:0] out_param_byte,
  output logic       out_last
);

  localparam int         CNT_W   = $clog2(MAX_PARAMS + 1);
  localparam int         ADDR_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [7:0] MAX_LEN = 8'(MAX_PARAMS + 2);
  localparam logic [7:0] MIN_LEN = 8'd2;

  sspd_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        err_r, err_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_inc, idx_inc;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [7:0]        oid_r, oid_nxt;
  logic [7:0]        oerr_r, oerr_nxt;
  logic [4:0]        oidx_r, oidx_nxt;
  logic [7:0]        obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;
  logic              out_load;

  logic              slot_free, may_emit, in_acc, drain_emit, drain_last;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        rd_data;

  // Buffer for the parameter bytes of the packet in flight
  sspd_param_buf #(
    .DEPTH  (MAX_PARAMS),
    .ADDR_W (ADDR_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake
  assign slot_free  = !out_valid_r || out_ready;
  assign may_emit   = (phase_r == sspd_pkg::PH_LEN) || (phase_r == sspd_pkg::PH_CHK);
  assign in_ready   = (phase_r != sspd_pkg::PH_DRAIN) && (slot_free || !may_emit);
  assign in_acc     = in_valid && in_ready;
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign idx_inc    = idx_r + CNT_W'(1);
  assign drain_emit = (phase_r == sspd_pkg::PH_DRAIN) && slot_free;
  assign drain_last = (idx_inc == cnt_r);
  assign wr_addr    = cnt_r[ADDR_W-1:0];

  // Parse one word, drain the buffer
  always_comb begin
    phase_nxt  = phase_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    err_nxt    = err_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx_inc[ADDR_W-1:0];
    out_load   = 1'b0;
    status_nxt = sspd_pkg::ST_DATA;
    oid_nxt    = id_r;
    oerr_nxt   = err_r;
    oidx_nxt   = 5'd0;
    obyte_nxt  = 8'd0;
    olast_nxt  = 1'b1;
    if (in_acc && in_abort) begin
      phase_nxt = sspd_pkg::PH_HUNT1;
    end else if (in_acc || phase_r == sspd_pkg::PH_DRAIN) begin
      unique case (phase_r)
        sspd_pkg::PH_HUNT1: begin
          if (in_rx_byte == sspd_pkg::HEADER_BYTE) begin
            phase_nxt = sspd_pkg::PH_HUNT2;
          end
        end
        sspd_pkg::PH_HUNT2: begin
          phase_nxt = (in_rx_byte == sspd_pkg::HEADER_BYTE) ? sspd_pkg::PH_ID
                                                            : sspd_pkg::PH_HUNT1;
        end
        sspd_pkg::PH_ID: begin
          // Treat extra 0xFF as more header
          if (in_rx_byte != sspd_pkg::HEADER_BYTE) begin
            id_nxt    = in_rx_byte;
            sum_nxt   = in_rx_byte;
            phase_nxt = sspd_pkg::PH_LEN;
          end
        end
        sspd_pkg::PH_LEN: begin
          len_nxt = in_rx_byte;
          sum_nxt = sum_r + in_rx_byte;
          if (in_rx_byte < MIN_LEN || in_rx_byte > MAX_LEN) begin
            out_load   = 1'b1;
            status_nxt = sspd_pkg::ST_BAD_LEN;
            oerr_nxt   = 8'd0;
            phase_nxt  = sspd_pkg::PH_HUNT1;
          end else begin
            phase_nxt = sspd_pkg::PH_ERR;
          end
        end
        sspd_pkg::PH_ERR: begin
          err_nxt   = in_rx_byte;
          sum_nxt   = sum_r + in_rx_byte;
          cnt_nxt   = '0;
          phase_nxt = (len_r == MIN_LEN) ? sspd_pkg::PH_CHK : sspd_pkg::PH_PARAM;
        end
        sspd_pkg::PH_PARAM: begin
          wr_en   = (32'(cnt_r) < 32'(MAX_PARAMS));
          cnt_nxt = cnt_inc;
          sum_nxt = sum_r + in_rx_byte;
          if (8'(cnt_inc) >= (len_r - MIN_LEN)) begin
            phase_nxt = sspd_pkg::PH_CHK;
          end
        end
        sspd_pkg::PH_CHK: begin
          phase_nxt = sspd_pkg::PH_HUNT1;
          if (in_rx_byte != ~sum_r) begin
            out_load   = 1'b1;
            status_nxt = sspd_pkg::ST_BAD_SUM;
          end else if (cnt_r == '0) begin
            out_load   = 1'b1;
            status_nxt = sspd_pkg::ST_EMPTY;
          end else begin
            // Start the readout with entry zero
            rd_en     = 1'b1;
            rd_addr   = '0;
            idx_nxt   = '0;
            phase_nxt = sspd_pkg::PH_DRAIN;
          end
        end
        sspd_pkg::PH_DRAIN: begin
          if (drain_emit) begin
            out_load   = 1'b1;
            status_nxt = sspd_pkg::ST_DATA;
            oidx_nxt   = 5'(idx_r);
            obyte_nxt  = rd_data;
            olast_nxt  = drain_last;
            if (drain_last) begin
              phase_nxt = sspd_pkg::PH_HUNT1;
            end else begin
              // Fetch the next entry while this one goes out
              rd_en   = 1'b1;
              idx_nxt = idx_inc;
            end
          end
        end
        default: begin
          phase_nxt = sspd_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  // Output register: load a new word, drop it when taken
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sspd_pkg::PH_HUNT1;
      id_r        <= 8'd0;
      len_r       <= 8'd0;
      err_r       <= 8'd0;
      sum_r       <= 8'd0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      id_r        <= id_nxt;
      len_r       <= len_nxt;
      err_r       <= err_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r <= status_nxt;
      oid_r    <= oid_nxt;
      oerr_r   <= oerr_nxt;
      oidx_r   <= oidx_nxt;
      obyte_r  <= obyte_nxt;
      olast_r  <= olast_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_servo_id    = oid_r;
  assign out_error_flags = oerr_r;
  assign out_param_index = oidx_r;
  assign out_param_byte  = obyte_r;
  assign out_last        = olast_r;

endmodule

[rtl/core/sspd_param_buf.sv]
// Parameter byte buffer: one write port, one registered read port.
module sspd_param_buf #(
  parameter int DEPTH  = sspd_pkg::DEFAULT_MAX_PARAMS,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write incoming parameter bytes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
